// File: src/sbba_pkg.sv
// Shared types, codes and sizes for the scratch block bump allocator.
// Used by the top level, the block-list RAM users and the port checker.
package sbba_pkg;

  localparam int NUM_BLOCKS  = 16;
  localparam int ID_W        = $clog2(NUM_BLOCKS);
  localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);

  localparam int ALIGN_W     = 4;
  localparam int SIZE_W      = 17;
  localparam int OFF_W       = 16;
  localparam int IDX_W       = 4;
  localparam int MAX_ALIGN   = 12;
  localparam int ALIGN_RESET = 8;
  localparam int MAX_BLOCK   = 65536;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  // Configuration register indexes
  localparam logic [0:0] CFG_ALIGN_LOG2  = 1'b0;
  localparam logic [0:0] CFG_BLOCK_BYTES = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_RESET = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_BLOCK  = 2'd1,
    STAT_OVERSIZE  = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_EXEC = 2'd2
  } state_e;

  // Result word layout, lowest field last
  typedef struct packed {
    logic [4:0]        pad;
    logic [4:0]        used_count;
    logic              fresh_block;
    logic [SIZE_W-1:0] byte_size;
    logic [OFF_W-1:0]  byte_offset;
    logic [3:0]        block_id;
  } res_t;

endpackage

// File: src/scratch_block_bump_allocator.sv
// Scratch block bump allocator: top level with control FSM and result register.
// Depends on sbba_pkg and two sbba_ram instances (used list, free stack).
//
// Order: allocate, query and unknown commands are latched at acceptance and
//   commit their result word in EXEC; a reset-frame command first passes
//   through WALK, which copies the used list into the free stack one entry
//   per cycle, and then commits in EXEC.
// Flow: one word at a time (accept, then commit); a reset frame holds the
//   input until it commits. A stalled result holds the commit.
// Reset: rst_ni clears all counters, flags and the result valid; the list RAMs
//   are not cleared, as entries are only read below their lengths.
module scratch_block_bump_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [16:0] req_size, [20:17] used_index, [23:21] zero
  input  logic [sbba_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] command
  input  logic [1:0]                         s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [3:0] block_id, [19:4] byte_offset, [36:20] byte_size, [37] fresh_block,
  // [42:38] used_count, [47:43] zero
  output logic [sbba_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [1:0] status
  output logic [1:0]                         m_axis_tuser,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [0:0]                         cfg_idx_i,
  input  logic [sbba_pkg::SIZE_W-1:0]        cfg_wdata_i
);

  localparam int ID_W  = sbba_pkg::ID_W;
  localparam int CNT_W = sbba_pkg::CNT_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [sbba_pkg::ALIGN_W-1:0] align_q;
  logic [sbba_pkg::SIZE_W-1:0]  bbytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q  <= sbba_pkg::ALIGN_W'(sbba_pkg::ALIGN_RESET);
      bbytes_q <= sbba_pkg::SIZE_W'(sbba_pkg::MAX_BLOCK);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sbba_pkg::CFG_ALIGN_LOG2:  align_q  <= cfg_wdata_i[sbba_pkg::ALIGN_W-1:0];
        sbba_pkg::CFG_BLOCK_BYTES: bbytes_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Allocator state
  // ---------------------------------------------------------------------------
  sbba_pkg::state_e state_q, state_d;
  logic              cur_valid_q, cur_valid_d;
  logic [ID_W-1:0]   cur_q, cur_d;
  logic [sbba_pkg::SIZE_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0]  used_len_q, used_len_d;
  logic [CNT_W-1:0]  free_len_q, free_len_d;
  logic [CNT_W-1:0]  next_fresh_q, next_fresh_d;
  logic [CNT_W-1:0]  walk_q, walk_d;
  logic              pend_q, pend_d;

  // latched command word
  sbba_pkg::cmd_e              cmd_q;
  logic [sbba_pkg::SIZE_W-1:0] req_q;
  logic [sbba_pkg::IDX_W-1:0]  idx_q;

  // result register
  logic              m_valid_q, m_valid_d;
  sbba_pkg::res_t    m_res_q, res;
  sbba_pkg::status_e m_stat_q, stat;

  logic s_fire;
  logic slot_free;
  logic commit;
  logic walk_rd;
  logic walk_done;

  // RAM ports
  logic            used_we, used_re, free_we, free_re;
  logic [ID_W-1:0] used_waddr, used_raddr, free_waddr, free_raddr;
  logic [ID_W-1:0] used_rdata, free_rdata;
  logic [4:0]      qpos;
  logic [CNT_W-1:0] free_top;

  sbba_pkg::cmd_e in_cmd;

  assign in_cmd    = sbba_pkg::cmd_e'(s_axis_tuser);
  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !m_valid_q || m_axis_tready;
  assign walk_done = (walk_q == used_len_q) && !pend_q;

  // Query position into the used list: the current block takes slot zero.
  assign qpos     = {1'b0, s_axis_tdata[20:17]} - {4'd0, cur_valid_q};
  assign free_top = free_len_q - CNT_W'(1);

  // ---------------------------------------------------------------------------
  // FSM: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbba_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_d = (in_cmd == sbba_pkg::CMD_RESET) ? sbba_pkg::ST_WALK : sbba_pkg::ST_EXEC;
        end
      end
      sbba_pkg::ST_WALK: begin
        if (walk_done) state_d = sbba_pkg::ST_EXEC;
      end
      sbba_pkg::ST_EXEC: begin
        if (slot_free) state_d = sbba_pkg::ST_IDLE;
      end
      default: state_d = sbba_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // FSM: outputs. Allocate and query read their RAM entry at acceptance,
  // allocate writes back in EXEC, so a later read never overlaps a pending
  // write of the same entry; the one-word-at-a-time FSM is the interlock.
  // ---------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    walk_rd       = 1'b0;
    commit        = 1'b0;
    case (state_q)
      sbba_pkg::ST_IDLE: s_axis_tready = 1'b1;
      sbba_pkg::ST_WALK: walk_rd       = (walk_q < used_len_q);
      sbba_pkg::ST_EXEC: commit        = slot_free;
      default: ;
    endcase
  end

  assign used_re    = (s_fire && (in_cmd == sbba_pkg::CMD_QUERY)) || walk_rd;
  assign used_raddr = walk_rd ? walk_q[ID_W-1:0] : ID_W'(qpos);
  assign free_re    = s_fire && (in_cmd == sbba_pkg::CMD_ALLOC);
  assign free_raddr = free_top[ID_W-1:0];

  // copy one used entry per cycle onto the free stack, in the cycle after its read
  assign free_we    = (state_q == sbba_pkg::ST_WALK) && pend_q
                      && (free_len_q < CNT_W'(sbba_pkg::NUM_BLOCKS));
  assign free_waddr = free_len_q[ID_W-1:0];

  // ---------------------------------------------------------------------------
  // Read-modify-write datapath
  // ---------------------------------------------------------------------------
  logic [sbba_pkg::ALIGN_W-1:0] align_eff;
  logic [17:0]                  mask;
  logic [17:0]                  aligned;
  logic [sbba_pkg::SIZE_W-1:0]  bsize;
  logic [18:0]                  fill_sum;
  logic                         oversize;
  logic                         need_new;
  logic                         fresh_ok;
  logic                         free_ok;
  logic [ID_W-1:0]              cur_new;
  logic [sbba_pkg::SIZE_W-1:0]  fill_new;
  logic                         fresh;
  logic [CNT_W:0]               q_count;

  assign align_eff = (align_q > sbba_pkg::ALIGN_W'(sbba_pkg::MAX_ALIGN))
                     ? sbba_pkg::ALIGN_W'(sbba_pkg::MAX_ALIGN) : align_q;
  assign mask      = (18'd1 << align_eff) - 18'd1;
  assign aligned   = ({1'b0, req_q} + mask) & ~mask;
  assign bsize     = (bbytes_q > sbba_pkg::SIZE_W'(sbba_pkg::MAX_BLOCK))
                     ? sbba_pkg::SIZE_W'(sbba_pkg::MAX_BLOCK) : bbytes_q;
  assign oversize  = aligned > {1'b0, bsize};
  assign fill_sum  = {2'b00, fill_q} + {1'b0, aligned};
  // a full 64 KiB block cannot report its offset, so it always moves on
  assign need_new  = cur_valid_q && ((fill_sum > {2'b00, bsize})
                     || (fill_q > sbba_pkg::SIZE_W'(sbba_pkg::MAX_BLOCK - 1)));
  assign fresh_ok  = next_fresh_q < CNT_W'(sbba_pkg::NUM_BLOCKS);
  assign free_ok   = free_len_q != '0;
  assign q_count   = (CNT_W+1)'(cur_valid_q) + (CNT_W+1)'(used_len_q);

  assign used_waddr = used_len_q[ID_W-1:0];

  always_comb begin
    cur_valid_d  = cur_valid_q;
    cur_d        = cur_q;
    fill_d       = fill_q;
    used_len_d   = used_len_q;
    free_len_d   = free_len_q;
    next_fresh_d = next_fresh_q;
    walk_d       = walk_rd ? walk_q + CNT_W'(1) : walk_q;
    pend_d       = walk_rd;
    used_we      = 1'b0;
    cur_new      = cur_q;
    fill_new     = fill_q;
    fresh        = 1'b0;
    res          = '0;
    stat         = sbba_pkg::STAT_OK;

    if (s_fire) walk_d = '0;
    if (free_we) free_len_d = free_len_q + CNT_W'(1);

    if (commit) begin
      case (cmd_q)
        sbba_pkg::CMD_ALLOC: begin
          res.byte_size = req_q;
          if (oversize) begin
            stat = sbba_pkg::STAT_OVERSIZE;
          end else if ((!cur_valid_q && !fresh_ok) || (need_new && !free_ok && !fresh_ok)) begin
            stat = sbba_pkg::STAT_NO_BLOCK;
          end else begin
            if (!cur_valid_q) begin
              cur_new      = ID_W'(next_fresh_q);
              next_fresh_d = next_fresh_q + CNT_W'(1);
              cur_valid_d  = 1'b1;
              fill_new     = '0;
              fresh        = 1'b1;
            end else if (need_new) begin
              // retire the current block onto the used list
              if (used_len_q < CNT_W'(sbba_pkg::NUM_BLOCKS)) begin
                used_we    = 1'b1;
                used_len_d = used_len_q + CNT_W'(1);
              end
              if (free_ok) begin
                free_len_d = free_top;
                cur_new    = free_rdata;
              end else begin
                cur_new      = ID_W'(next_fresh_q);
                next_fresh_d = next_fresh_q + CNT_W'(1);
                fresh        = 1'b1;
              end
              fill_new = '0;
            end
            cur_d           = cur_new;
            res.block_id    = 4'(cur_new);
            res.byte_offset = fill_new[sbba_pkg::OFF_W-1:0];
            res.fresh_block = fresh;
            fill_d          = sbba_pkg::SIZE_W'({1'b0, fill_new} + aligned);
          end
        end
        sbba_pkg::CMD_RESET: begin
          used_len_d = '0;
          fill_d     = '0;
        end
        sbba_pkg::CMD_QUERY: begin
          if ((CNT_W+1)'(idx_q) >= q_count) begin
            stat = sbba_pkg::STAT_BAD_INDEX;
          end else if (cur_valid_q && (idx_q == '0)) begin
            res.block_id = 4'(cur_q);
          end else begin
            res.block_id = 4'(used_rdata);
          end
        end
        default: ;
      endcase
      res.used_count = 5'(cur_valid_d) + 5'(used_len_d);
    end
  end

  // result valid: set on commit, drop on handshake
  always_comb begin
    m_valid_d = m_valid_q;
    if (m_axis_tready) m_valid_d = 1'b0;
    if (commit) m_valid_d = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sbba_pkg::ST_IDLE;
      cur_valid_q  <= 1'b0;
      cur_q        <= '0;
      fill_q       <= '0;
      used_len_q   <= '0;
      free_len_q   <= '0;
      next_fresh_q <= '0;
      walk_q       <= '0;
      pend_q       <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_valid_q  <= cur_valid_d;
      cur_q        <= cur_d;
      fill_q       <= fill_d;
      used_len_q   <= used_len_d;
      free_len_q   <= free_len_d;
      next_fresh_q <= next_fresh_d;
      walk_q       <= walk_d;
      pend_q       <= pend_d;
      m_valid_q    <= m_valid_d;
    end
  end

  // payload: latch the command word and the result, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q <= in_cmd;
      req_q <= s_axis_tdata[16:0];
      idx_q <= s_axis_tdata[20:17];
    end
    if (commit) begin
      m_res_q  <= res;
      m_stat_q <= stat;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_res_q;
  assign m_axis_tuser  = m_stat_q;

  // ---------------------------------------------------------------------------
  // Block-list memories
  // ---------------------------------------------------------------------------
  sbba_ram #(
    .WIDTH (ID_W),
    .DEPTH (sbba_pkg::NUM_BLOCKS)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (cur_q),
    .re_i    (used_re),
    .raddr_i (used_raddr),
    .rdata_o (used_rdata)
  );

  sbba_ram #(
    .WIDTH (ID_W),
    .DEPTH (sbba_pkg::NUM_BLOCKS)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (used_rdata),
    .re_i    (free_re),
    .raddr_i (free_raddr),
    .rdata_o (free_rdata)
  );

endmodule

// File: src/sbba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No package dependency; width and depth come in as parameters.
module sbba_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sbba_checker.sv
// Port-level checker for the scratch block bump allocator, bound to the top.
// Depends on sbba_pkg for the result layout and status codes.
module sbba_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [sbba_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [1:0]                       s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [sbba_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                       m_axis_tuser,
  input logic                             cfg_we_i,
  input logic [0:0]                       cfg_idx_i,
  input logic [sbba_pkg::SIZE_W-1:0]      cfg_wdata_i
);

  sbba_pkg::res_t res;
  assign res = m_axis_tdata;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // one command in flight: ready drops right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a command is in flight");

  // a new result appears only while input is held off
  a_res_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result word without a command in flight");

  // a fresh block is only issued by a successful allocation at offset zero
  a_fresh_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.fresh_block |->
      (m_axis_tuser == sbba_pkg::STAT_OK) && (res.byte_offset == '0))
    else $error("fresh block flagged on failed or nonzero-offset result");

endmodule

bind scratch_block_bump_allocator sbba_checker u_sbba_checker (.*);
